[src/look_at_view_matrix_assert.svh]
// ----------------------------------------------------------------------------
// look_at_view_matrix_assert.svh
// Assertion macros for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// pre implies post on the same edge
`define LAV_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("look_at_view_matrix: assertion failed");

// a unit axis component stays inside [-1.0, 1.0] in Q2.30
`define LAV_ASSERT_UNIT(lbl, sig) \
  `LAV_ASSERT_NOW(lbl, out_valid, \
    (((sig) <= 32'sd1073741824) && ((sig) >= -32'sd1073741824)))

`endif

[src/lav_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, latencies and rounding helpers of the look-at pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] wide_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int NORM_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int TOP_LAT    = 2 * NORM_LAT + 8;

  // shift right by 30, round half away from zero
  function automatic logic signed [65:0] rnd30(input logic signed [65:0] x);
    logic [65:0] mag;
    logic [65:0] m;
    mag = x[65] ? 66'(-x) : 66'(x);
    m   = (mag + 66'd536870912) >> 30;
    return x[65] ? $signed(66'(-m)) : $signed(m);
  endfunction

  function automatic q_t clamp_q30(input logic signed [65:0] x);
    if (x > 66'sd1073741824) return 32'sd1073741824;
    else if (x < -66'sd1073741824) return -32'sd1073741824;
    else return x[31:0];
  endfunction

  function automatic q_t sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    else if (x < -66'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

endpackage

[src/lav_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module lav_sqrt import lav_pkg::*; #(
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [63:0]     in_s,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output logic [SB_W-1:0] out_sb
);

  logic [SQRT_STEPS-1:0] v_r;
  logic [32:0]     rem_r  [SQRT_STEPS];
  logic [32:0]     rem_nxt[SQRT_STEPS];
  logic [31:0]     root_r  [SQRT_STEPS];
  logic [31:0]     root_nxt[SQRT_STEPS];
  logic [63:0]     s_r  [SQRT_STEPS];
  logic [63:0]     s_nxt[SQRT_STEPS];
  logic [SB_W-1:0] sb_r  [SQRT_STEPS];
  logic [SB_W-1:0] sb_nxt[SQRT_STEPS];

  always_comb begin
    logic [32:0]     rem_i;
    logic [31:0]     root_i;
    logic [63:0]     s_i;
    logic [SB_W-1:0] sb_i;
    logic [34:0]     acc;
    logic [34:0]     trial;
    logic            ge;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rem_i  = '0;
        root_i = '0;
        s_i    = in_s;
        sb_i   = in_sb;
      end else begin
        rem_i  = rem_r[k-1];
        root_i = root_r[k-1];
        s_i    = s_r[k-1];
        sb_i   = sb_r[k-1];
      end
      acc   = {rem_i, s_i[63:62]};
      trial = {1'b0, root_i, 2'b01};
      ge    = (acc >= trial);
      rem_nxt[k]  = ge ? 33'(acc - trial) : acc[32:0];
      root_nxt[k] = {root_i[30:0], ge};
      s_nxt[k]    = {s_i[61:0], 2'b00};
      sb_nxt[k]   = sb_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[SQRT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      s_r[k]    <= s_nxt[k];
      sb_r[k]   <= sb_nxt[k];
    end
  end

  assign out_valid = v_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];
  assign out_sb    = sb_r[SQRT_STEPS-1];

endmodule

[src/lav_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider, three lanes over one shared divisor.
// ----------------------------------------------------------------------------
module lav_div import lav_pkg::*; #(
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [61:0]     in_n [3],
  input  logic [31:0]     in_d,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [30:0]     out_q [3],
  output logic [SB_W-1:0] out_sb
);

  logic [DIV_STEPS-1:0] v_r;
  logic [31:0]     rem_r  [DIV_STEPS][3];
  logic [31:0]     rem_nxt[DIV_STEPS][3];
  logic [30:0]     n_r  [DIV_STEPS][3];
  logic [30:0]     n_nxt[DIV_STEPS][3];
  logic [30:0]     q_r  [DIV_STEPS][3];
  logic [30:0]     q_nxt[DIV_STEPS][3];
  logic [31:0]     d_r  [DIV_STEPS];
  logic [31:0]     d_nxt[DIV_STEPS];
  logic [SB_W-1:0] sb_r  [DIV_STEPS];
  logic [SB_W-1:0] sb_nxt[DIV_STEPS];

  always_comb begin
    logic [31:0] rem_i;
    logic [30:0] n_i;
    logic [30:0] q_i;
    logic [31:0] d_i;
    logic [32:0] acc;
    logic        ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      d_i = (k == 0) ? in_d : d_r[k-1];
      d_nxt[k]  = d_i;
      sb_nxt[k] = (k == 0) ? in_sb : sb_r[k-1];
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          // top bits of the numerator are below the divisor
          rem_i = {1'b0, in_n[l][61:31]};
          n_i   = in_n[l][30:0];
          q_i   = '0;
        end else begin
          rem_i = rem_r[k-1][l];
          n_i   = n_r[k-1][l];
          q_i   = q_r[k-1][l];
        end
        acc = {rem_i, n_i[30]};
        ge  = (acc >= {1'b0, d_i});
        rem_nxt[k][l] = ge ? 32'(acc - {1'b0, d_i}) : acc[31:0];
        n_nxt[k][l]   = {n_i[29:0], 1'b0};
        q_nxt[k][l]   = {q_i[29:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      d_r[k]  <= d_nxt[k];
      sb_r[k] <= sb_nxt[k];
      for (int l = 0; l < 3; l++) begin
        rem_r[k][l] <= rem_nxt[k][l];
        n_r[k][l]   <= n_nxt[k][l];
        q_r[k][l]   <= q_nxt[k][l];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_sb    = sb_r[DIV_STEPS-1];
  always_comb begin
    for (int l = 0; l < 3; l++) out_q[l] = q_r[DIV_STEPS-1][l];
  end

endmodule

[src/lav_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: Q2.30 unit vector from 64-bit components.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  wide_t           in_c [3],
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output q_t              out_o [3],
  output logic [SB_W-1:0] out_sb
);

  localparam int SQ_SB  = 3 * 31 + 4 + SB_W;
  localparam int DIV_SB = 4 + SB_W;

  // stage 1: magnitudes, max and its leading one
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [63:0] m1_r [3];
  logic [2:0]  neg1_r, neg2_r, neg3_r, neg4_r;
  logic [5:0]  p1_r;
  logic        z1_r, z2_r, z3_r, z4_r;
  logic [SB_W-1:0] sb1_r, sb2_r, sb3_r, sb4_r;
  logic [63:0] mag [3];
  logic [63:0] mx;
  logic [5:0]  p;

  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = in_c[i][63] ? 64'(-in_c[i]) : 64'(in_c[i]);
    mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mx) mx = mag[2];
    p = '0;
    for (int b = 0; b < 64; b++) begin
      if (mx[b]) p = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1_r[i]   <= mag[i];
      neg1_r[i] <= in_c[i][63];
    end
    p1_r  <= p;
    z1_r  <= (mx == '0);
    sb1_r <= in_sb;
  end

  // stage 2: bring the largest magnitude into [2^30, 2^31)
  logic [30:0] m2_r [3];
  logic [63:0] shf [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shf[i] = (p1_r >= 6'd30) ? (m1_r[i] >> (p1_r - 6'd30))
                               : (m1_r[i] << (6'd30 - p1_r));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) m2_r[i] <= shf[i][30:0];
    neg2_r <= neg1_r;
    z2_r   <= z1_r;
    sb2_r  <= sb1_r;
  end

  // stage 3: squares, stage 4: sum of squares
  logic [61:0] sq3_r [3];
  logic [30:0] m3_r [3];
  logic [30:0] m4_r [3];
  logic [63:0] s4_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq3_r[i] <= m2_r[i] * m2_r[i];
      m3_r[i]  <= m2_r[i];
      m4_r[i]  <= m3_r[i];
    end
    neg3_r <= neg2_r;
    z3_r   <= z2_r;
    sb3_r  <= sb2_r;
    s4_r   <= {2'b00, sq3_r[0]} + {2'b00, sq3_r[1]} + {2'b00, sq3_r[2]};
    neg4_r <= neg3_r;
    z4_r   <= z3_r;
    sb4_r  <= sb3_r;
  end

  // square root
  logic             sq_v;
  logic [31:0]      sq_root;
  logic [SQ_SB-1:0] sq_sb;

  lav_sqrt #(.SB_W(SQ_SB)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v4_r),
    .in_s     (s4_r),
    .in_sb    ({m4_r[0], m4_r[1], m4_r[2], neg4_r, z4_r, sb4_r}),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  // stage 5: rounded numerators
  logic [61:0]       n5_r [3];
  logic [31:0]       d5_r;
  logic [DIV_SB-1:0] dsb5_r;

  always_ff @(posedge clk) begin
    n5_r[0] <= {1'b0, sq_sb[SB_W+66 +: 31], 30'd0} + {31'd0, sq_root[31:1]};
    n5_r[1] <= {1'b0, sq_sb[SB_W+35 +: 31], 30'd0} + {31'd0, sq_root[31:1]};
    n5_r[2] <= {1'b0, sq_sb[SB_W+4  +: 31], 30'd0} + {31'd0, sq_root[31:1]};
    d5_r    <= sq_root;
    dsb5_r  <= sq_sb[DIV_SB-1:0];
  end

  logic              dv_v;
  logic [30:0]       dv_q [3];
  logic [DIV_SB-1:0] dv_sb;

  lav_div #(.SB_W(DIV_SB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v5_r),
    .in_n     (n5_r),
    .in_d     (d5_r),
    .in_sb    (dsb5_r),
    .out_valid(dv_v),
    .out_q    (dv_q),
    .out_sb   (dv_sb)
  );

  // stage 6: sign and zero-vector case
  q_t              o6_r [3];
  logic [SB_W-1:0] sb6_r;
  logic [2:0]      dneg;

  assign dneg = dv_sb[SB_W+3:SB_W+1];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_sb[SB_W]) o6_r[i] <= '0;
      else if (dneg[i]) o6_r[i] <= -$signed({1'b0, dv_q[i]});
      else o6_r[i] <= $signed({1'b0, dv_q[i]});
    end
    sb6_r <= dv_sb[SB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= sq_v;
      v6_r <= dv_v;
    end
  end

  assign out_valid = v6_r;
  assign out_sb    = sb6_r;
  always_comb begin
    for (int i = 0; i < 3; i++) out_o[i] = o6_r[i];
  end

endmodule

[src/look_at_view_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix: rotation axes (Q2.30) and translation
// (Q16.16, saturated) from eye, target and up vectors (Q16.16).
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | start & !busy           | eye, target, upvec (9 x s32)
//  out      | out_valid, one cycle    | right, trueup, back, shift (12 x s32)
//
//  Fully pipelined: one item per cycle. Latency is set by the two
//  normalizers, each 69 stages: a 32-stage square root and a 31-stage
//  divider, one bit per stage. busy is always low; the pipeline has no
//  stall path since results cannot be held off. Reset (synchronous, rst_n
//  low) clears valid bits only.
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  q_t   in_eye_x,
  input  q_t   in_eye_y,
  input  q_t   in_eye_z,
  input  q_t   in_target_x,
  input  q_t   in_target_y,
  input  q_t   in_target_z,
  input  q_t   in_upvec_x,
  input  q_t   in_upvec_y,
  input  q_t   in_upvec_z,
  output logic out_valid,
  output q_t   out_right_x,
  output q_t   out_right_y,
  output q_t   out_right_z,
  output q_t   out_trueup_x,
  output q_t   out_trueup_y,
  output q_t   out_trueup_z,
  output q_t   out_back_x,
  output q_t   out_back_y,
  output q_t   out_back_z,
  output q_t   out_shift_x,
  output q_t   out_shift_y,
  output q_t   out_shift_z
);

  localparam int SB_W = 6 * 32;

  assign busy = 1'b0;

  // s0: eye - target (33 bits), register inputs
  logic        v0_r;
  wide_t       d0_r [3];
  logic [SB_W-1:0] sb0_r;

  always_ff @(posedge clk) begin
    d0_r[0] <= 64'(33'(in_eye_x) - 33'(in_target_x));
    d0_r[1] <= 64'(33'(in_eye_y) - 33'(in_target_y));
    d0_r[2] <= 64'(33'(in_eye_z) - 33'(in_target_z));
    sb0_r   <= {in_eye_x, in_eye_y, in_eye_z, in_upvec_x, in_upvec_y, in_upvec_z};
  end

  // back = normalize(eye - target); sideband carries eye and up
  logic            n1_v;
  q_t              back1 [3];
  logic [SB_W-1:0] n1_sb;

  lav_norm #(.SB_W(SB_W)) u_norm_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_c     (d0_r),
    .in_sb    (sb0_r),
    .out_valid(n1_v),
    .out_o    (back1),
    .out_sb   (n1_sb)
  );

  q_t eye1 [3];
  q_t up1  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye1[i] = n1_sb[SB_W-1-32*i -: 32];
      up1[i]  = n1_sb[95-32*i -: 32];
    end
  end

  // c1: up x back partial products, c2: differences
  logic  v_c1_r, v_c2_r;
  wide_t pc_r [6];
  wide_t cr_r [3];
  q_t    eye_c1_r [3];
  q_t    back_c1_r [3];
  logic [SB_W-1:0] sb_c2_r;

  always_ff @(posedge clk) begin
    pc_r[0] <= up1[1] * back1[2];
    pc_r[1] <= up1[2] * back1[1];
    pc_r[2] <= up1[2] * back1[0];
    pc_r[3] <= up1[0] * back1[2];
    pc_r[4] <= up1[0] * back1[1];
    pc_r[5] <= up1[1] * back1[0];
    for (int i = 0; i < 3; i++) begin
      eye_c1_r[i]  <= eye1[i];
      back_c1_r[i] <= back1[i];
    end
    cr_r[0] <= pc_r[0] - pc_r[1];
    cr_r[1] <= pc_r[2] - pc_r[3];
    cr_r[2] <= pc_r[4] - pc_r[5];
    sb_c2_r <= {eye_c1_r[0], eye_c1_r[1], eye_c1_r[2],
                back_c1_r[0], back_c1_r[1], back_c1_r[2]};
  end

  // right = normalize(up x back); sideband carries eye and back
  logic            n2_v;
  q_t              right2 [3];
  logic [SB_W-1:0] n2_sb;

  lav_norm #(.SB_W(SB_W)) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v_c2_r),
    .in_c     (cr_r),
    .in_sb    (sb_c2_r),
    .out_valid(n2_v),
    .out_o    (right2),
    .out_sb   (n2_sb)
  );

  q_t eye2 [3];
  q_t back2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye2[i]  = n2_sb[SB_W-1-32*i -: 32];
      back2[i] = n2_sb[95-32*i -: 32];
    end
  end

  // t1: back x right products, t2: true up rounded and clamped
  logic  v_t1_r, v_t2_r, v_t3_r, v_t4_r, v_t5_r;
  wide_t pt_r [6];
  q_t    eye_t1_r [3], eye_t2_r [3];
  q_t    rgt_t1_r [3], rgt_t2_r [3], rgt_t3_r [3], rgt_t4_r [3];
  q_t    bck_t1_r [3], bck_t2_r [3], bck_t3_r [3], bck_t4_r [3];
  q_t    tu_t2_r [3], tu_t3_r [3], tu_t4_r [3];

  always_ff @(posedge clk) begin
    pt_r[0] <= back2[1] * right2[2];
    pt_r[1] <= back2[2] * right2[1];
    pt_r[2] <= back2[2] * right2[0];
    pt_r[3] <= back2[0] * right2[2];
    pt_r[4] <= back2[0] * right2[1];
    pt_r[5] <= back2[1] * right2[0];
    for (int i = 0; i < 3; i++) begin
      eye_t1_r[i] <= eye2[i];
      rgt_t1_r[i] <= right2[i];
      bck_t1_r[i] <= back2[i];
      tu_t2_r[i]  <= clamp_q30(rnd30(66'(pt_r[2*i]) - 66'(pt_r[2*i+1])));
      eye_t2_r[i] <= eye_t1_r[i];
      rgt_t2_r[i] <= rgt_t1_r[i];
      bck_t2_r[i] <= bck_t1_r[i];
    end
  end

  // t3: axis . eye products, t4: dot sums, t5: translation
  wide_t pd_r [3][3];
  logic signed [65:0] dot_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pd_r[0][i]  <= rgt_t2_r[i] * eye_t2_r[i];
      pd_r[1][i]  <= tu_t2_r[i] * eye_t2_r[i];
      pd_r[2][i]  <= bck_t2_r[i] * eye_t2_r[i];
      rgt_t3_r[i] <= rgt_t2_r[i];
      tu_t3_r[i]  <= tu_t2_r[i];
      bck_t3_r[i] <= bck_t2_r[i];
      dot_r[i]    <= 66'(pd_r[i][0]) + 66'(pd_r[i][1]) + 66'(pd_r[i][2]);
      rgt_t4_r[i] <= rgt_t3_r[i];
      tu_t4_r[i]  <= tu_t3_r[i];
      bck_t4_r[i] <= bck_t3_r[i];
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    out_right_x  <= rgt_t4_r[0];
    out_right_y  <= rgt_t4_r[1];
    out_right_z  <= rgt_t4_r[2];
    out_trueup_x <= tu_t4_r[0];
    out_trueup_y <= tu_t4_r[1];
    out_trueup_z <= tu_t4_r[2];
    out_back_x   <= bck_t4_r[0];
    out_back_y   <= bck_t4_r[1];
    out_back_z   <= bck_t4_r[2];
    out_shift_x  <= sat32(rnd30(-dot_r[0]));
    out_shift_y  <= sat32(rnd30(-dot_r[1]));
    out_shift_z  <= sat32(rnd30(-dot_r[2]));
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v_c1_r <= 1'b0;
      v_c2_r <= 1'b0;
      v_t1_r <= 1'b0;
      v_t2_r <= 1'b0;
      v_t3_r <= 1'b0;
      v_t4_r <= 1'b0;
      v_t5_r <= 1'b0;
    end else begin
      v0_r   <= start & ~busy;
      v_c1_r <= n1_v;
      v_c2_r <= v_c1_r;
      v_t1_r <= n2_v;
      v_t2_r <= v_t1_r;
      v_t3_r <= v_t2_r;
      v_t4_r <= v_t3_r;
      v_t5_r <= v_t4_r;
    end
  end

  assign out_valid = v_t5_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`include "look_at_view_matrix_assert.svh"

  // every result goes back to an accepted item exactly one latency earlier
  `LAV_ASSERT_NOW(a_latency, out_valid, $past(start, TOP_LAT))
  `LAV_ASSERT_UNIT(a_trueup_unit, out_trueup_x)
  `LAV_ASSERT_UNIT(a_right_unit, out_right_x)
  // eye on target zeroes every axis and translation; one component of each is checked
  `LAV_ASSERT_NOW(a_zero_back,
    out_valid && (out_back_x == '0) && (out_back_y == '0) && (out_back_z == '0),
    (out_right_y == '0) && (out_trueup_z == '0) && (out_shift_z == '0))

endmodule
